FILE: sv/ucb_pkg.sv
// shared widths, constants and reset values of the ucb1 score unit
`default_nettype none
package ucb_pkg;

    // item field widths
    localparam int SCORE_W  = 24;
    localparam int VISIT_W  = 24;
    localparam int WEIGHT_W = 16;
    localparam int OUT_W    = 40;

    // default configuration of the datapath
    localparam int COUNT_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // exploration weight after reset, about sqrt(2) in Q4.12
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd5793;

    // ln(2) in Q0.30
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // saturation limit of the result
    localparam logic [OUT_W-1:0] OUT_MAX = 40'h7F_FFFF_FFFF;

endpackage
`default_nettype wire

FILE: sv/ucb_in_if.sv
// input channel: node score and visit counts
`default_nettype none
interface ucb_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ucb_pkg::SCORE_W-1:0] node_score;
    logic [ucb_pkg::VISIT_W-1:0]        node_visits;
    logic [ucb_pkg::VISIT_W-1:0]        parent_visits;

    modport source (output valid, node_score, node_visits, parent_visits, input ready);
    modport sink (input valid, node_score, node_visits, parent_visits, output ready);
endinterface
`default_nettype wire

FILE: sv/ucb_out_if.sv
// output channel: ucb1 score and infinite flag
`default_nettype none
interface ucb_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ucb_pkg::OUT_W-1:0] ucb_value;
    logic                             is_infinite;

    modport source (output valid, ucb_value, is_infinite, input ready);
    modport sink (input valid, ucb_value, is_infinite, output ready);
endinterface
`default_nettype wire

FILE: sv/ucb_front.sv
// front end: accepts items and classifies them for the back pipeline
`default_nettype none
module ucb_front #(
    parameter int COUNT_BITS = ucb_pkg::COUNT_BITS_DEF,
    parameter int K_W        = $clog2(COUNT_BITS)
) (
    ucb_in_if.sink                      in_ch,
    input  wire logic                   queue_full,
    output logic                        push,
    output logic                        inf,
    output logic                        neg,
    output logic [K_W-1:0]              k,
    output logic [ucb_pkg::SCORE_W-1:0] mag,
    output logic [COUNT_BITS-1:0]       n,
    output logic [COUNT_BITS-1:0]       total
);

    // handshake
    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

    // count fields and zero test
    assign n     = COUNT_BITS'(in_ch.node_visits);
    assign total = COUNT_BITS'(in_ch.parent_visits);
    assign inf   = (n == '0) || (total == '0);

    // sign and magnitude of the score, most negative value maps to itself
    assign neg = in_ch.node_score[ucb_pkg::SCORE_W-1];
    assign mag = neg ? (ucb_pkg::SCORE_W)'(-in_ch.node_score) : in_ch.node_score;

    // index of the top set bit of the parent count
    always_comb
    begin
        k = '0;
        for (int i = 0; i < COUNT_BITS; i++)
        begin
            if (total[i])
            begin
                k = K_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/ucb_queue.sv
// short fifo that decouples the front end from the back pipeline
`default_nettype none
module ucb_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      head
);

    localparam int DEPTH = ucb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ucb_back.sv
// back pipeline: divides, takes log2, ln, root and sums the ucb1 score
`default_nettype none
module ucb_back #(
    parameter int COUNT_BITS = ucb_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = ucb_pkg::FRAC_BITS_DEF,
    parameter int K_W        = $clog2(COUNT_BITS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ucb_pkg::WEIGHT_W-1:0]  weight,
    input  wire logic                          q_valid,
    output logic                               adv,
    input  wire logic                          q_inf,
    input  wire logic                          q_neg,
    input  wire logic [K_W-1:0]                q_k,
    input  wire logic [ucb_pkg::SCORE_W-1:0]   q_mag,
    input  wire logic [COUNT_BITS-1:0]         q_n,
    input  wire logic [COUNT_BITS-1:0]         q_total,
    ucb_out_if.source                          out_ch
);

    localparam int CW     = COUNT_BITS;
    localparam int F      = FRAC_BITS;
    localparam int LF     = F + 4;
    localparam int LG_W   = K_W + LF;
    localparam int QD_W   = ucb_pkg::SCORE_W + F;
    localparam int RD_W   = LG_W + F - 4;
    localparam int SQ_I   = (RD_W + 1) / 2;
    localparam int EX_W   = ucb_pkg::WEIGHT_W + SQ_I;
    localparam int EXP_W  = EX_W - 11;
    localparam int MAX_A  = (QD_W > EXP_W) ? QD_W : EXP_W;
    localparam int MAX_B  = (MAX_A > ucb_pkg::OUT_W) ? MAX_A : ucb_pkg::OUT_W;
    localparam int SUM_W  = MAX_B + 2;

    // stage map
    localparam int J_LN_MUL = LF + 1;
    localparam int J_LN_RND = LF + 2;
    localparam int J_RDIV0  = LF + 3;
    localparam int J_SQ0    = J_RDIV0 + RD_W;
    localparam int J_EMUL   = J_SQ0 + SQ_I;
    localparam int J_ERND   = J_EMUL + 1;
    localparam int J_SUM    = J_ERND + 1;
    localparam int NS       = J_SUM + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(ucb_pkg::OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic                        inf;
        logic                        neg;
        logic [CW-1:0]               n;
        logic [K_W-1:0]              k;
        logic [30:0]                 m;
        logic [LF-1:0]               lgf;
        logic [CW-1:0]               rem1;
        logic [QD_W-1:0]             dq1;
        logic [LG_W+29:0]            lnp;
        logic [CW-1:0]               rem2;
        logic [RD_W-1:0]             dq2;
        logic [2*SQ_I-1:0]           rad;
        logic [SQ_I+1:0]             srem;
        logic [SQ_I-1:0]             root;
        logic [EX_W-1:0]             e;
        logic [EXP_W-1:0]            expl;
        logic [ucb_pkg::OUT_W-1:0]   res;
    } stage_t;

    stage_t          st_reg  [NS];
    stage_t          st_next [NS];
    logic [NS-1:0]   vld_reg, vld_next;

    // whole pipeline moves unless a finished item is held at the output
    assign adv = !vld_reg[NS-1] || out_ch.ready;

    // entry stage: normalize the mantissa and load the score divider
    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].inf   = q_inf;
        st_next[0].neg   = q_neg;
        st_next[0].n     = q_n;
        st_next[0].k     = q_k;
        st_next[0].m     = 31'(({q_total, 30'b0}) >> q_k);
        st_next[0].rem1  = '0;
        st_next[0].dq1   = {q_mag, {F{1'b0}}};
    end

    for (genvar j = 1; j < NS; j++)
    begin : g_stage
        always_comb
        begin
            stage_t                  p;
            stage_t                  s;
            logic [CW:0]             r1;
            logic [CW:0]             r2;
            logic [61:0]             sq;
            logic [31:0]             s32;
            logic [LG_W+30:0]        pl;
            logic [2*SQ_I-1:0]       rad_in;
            logic [SQ_I+1:0]         srem_in;
            logic [SQ_I-1:0]         root_in;
            logic [SQ_I+3:0]         rs;
            logic [SQ_I+3:0]         ts;
            logic [EX_W:0]           er;
            logic signed [SUM_W-1:0] sx;
            logic signed [SUM_W-1:0] sum;
            p       = st_reg[j-1];
            s       = p;
            r1      = '0;
            r2      = '0;
            sq      = '0;
            s32     = '0;
            pl      = '0;
            rad_in  = '0;
            srem_in = '0;
            root_in = '0;
            rs      = '0;
            ts      = '0;
            er      = '0;
            sx      = '0;
            sum     = '0;

            // score divider, one quotient bit a stage
            if (j <= QD_W)
            begin
                r1 = {p.rem1, p.dq1[QD_W-1]};
                if (r1 >= {1'b0, p.n})
                begin
                    s.rem1 = CW'(r1 - {1'b0, p.n});
                    s.dq1  = {p.dq1[QD_W-2:0], 1'b1};
                end
                else
                begin
                    s.rem1 = CW'(r1);
                    s.dq1  = {p.dq1[QD_W-2:0], 1'b0};
                end
            end

            // log2 fraction, one squaring a stage
            if (j <= LF)
            begin
                sq  = p.m * p.m;
                s32 = sq[61:30];
                if (s32[31])
                begin
                    s.m   = s32[31:1];
                    s.lgf = {p.lgf[LF-2:0], 1'b1};
                end
                else
                begin
                    s.m   = s32[30:0];
                    s.lgf = {p.lgf[LF-2:0], 1'b0};
                end
            end

            // ln = log2 * ln(2)
            if (j == J_LN_MUL)
            begin
                s.lnp = {p.k, p.lgf} * ucb_pkg::LN2_Q30;
            end

            // round ln and load the ratio divider
            if (j == J_LN_RND)
            begin
                pl     = {1'b0, p.lnp} + (LG_W + 31)'(1 << 29);
                s.rem2 = '0;
                s.dq2  = {pl[30 +: LG_W], {(F - 4){1'b0}}};
            end

            // ratio divider, one quotient bit a stage
            if (j >= J_RDIV0 && j < J_SQ0)
            begin
                r2 = {p.rem2, p.dq2[RD_W-1]};
                if (r2 >= {1'b0, p.n})
                begin
                    s.rem2 = CW'(r2 - {1'b0, p.n});
                    s.dq2  = {p.dq2[RD_W-2:0], 1'b1};
                end
                else
                begin
                    s.rem2 = CW'(r2);
                    s.dq2  = {p.dq2[RD_W-2:0], 1'b0};
                end
            end

            // integer square root, one root bit a stage
            if (j >= J_SQ0 && j < J_EMUL)
            begin
                if (j == J_SQ0)
                begin
                    rad_in  = (2 * SQ_I)'(p.dq2);
                    srem_in = '0;
                    root_in = '0;
                end
                else
                begin
                    rad_in  = p.rad;
                    srem_in = p.srem;
                    root_in = p.root;
                end
                rs = {srem_in, rad_in[2*SQ_I-1 -: 2]};
                ts = {2'b00, root_in, 2'b01};
                if (rs >= ts)
                begin
                    s.srem = (SQ_I + 2)'(rs - ts);
                    s.root = {root_in[SQ_I-2:0], 1'b1};
                end
                else
                begin
                    s.srem = (SQ_I + 2)'(rs);
                    s.root = {root_in[SQ_I-2:0], 1'b0};
                end
                s.rad = rad_in << 2;
            end

            // exploration term c * root
            if (j == J_EMUL)
            begin
                s.e = weight * p.root;
            end

            // round off the Q4.12 weight fraction
            if (j == J_ERND)
            begin
                er     = {1'b0, p.e} + (EX_W + 1)'(2048);
                s.expl = er[EX_W:12];
            end

            // signed sum, saturation and infinite override
            if (j == J_SUM)
            begin
                sx = SUM_W'(p.dq1);
                if (p.neg)
                begin
                    sx = -sx;
                end
                sum = sx + SUM_W'(p.expl);
                if (p.inf)
                begin
                    s.res = ucb_pkg::OUT_MAX;
                end
                else if (sum > SAT_HI)
                begin
                    s.res = ucb_pkg::OUT_MAX;
                end
                else if (sum < SAT_LO)
                begin
                    s.res = (ucb_pkg::OUT_W)'(SAT_LO);
                end
                else
                begin
                    s.res = (ucb_pkg::OUT_W)'(sum);
                end
            end

            st_next[j] = s;
        end
    end

    // valid bits
    assign vld_next = {vld_reg[NS-2:0], q_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // output channel
    assign out_ch.valid       = vld_reg[NS-1];
    assign out_ch.ucb_value   = st_reg[NS-1].res;
    assign out_ch.is_infinite = st_reg[NS-1].inf;

endmodule
`default_nettype wire

FILE: sv/ucb1_score_unit.sv
// top level of the ucb1 score unit
// throughput: one item per cycle unless a finished result is held at the output, set
//   by the fully pipelined log, divide and root stages that all advance together
// reset: asynchronous, clears the queue and all valid bits, weight to 5793
`default_nettype none
module ucb1_score_unit #(
    parameter int COUNT_BITS = ucb_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = ucb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ucb_in_if.sink                            in_ch,
    ucb_out_if.source                         out_ch,
    input  wire logic                         cfg_we,
    input  wire logic [ucb_pkg::WEIGHT_W-1:0] cfg_wdata
);

    localparam int K_W  = $clog2(COUNT_BITS);
    localparam int QI_W = 2 + K_W + ucb_pkg::SCORE_W + 2 * COUNT_BITS;

    logic [ucb_pkg::WEIGHT_W-1:0] weight_reg;

    logic                         push, full, empty, pop, adv;
    logic                         f_inf, f_neg;
    logic [K_W-1:0]               f_k;
    logic [ucb_pkg::SCORE_W-1:0]  f_mag;
    logic [COUNT_BITS-1:0]        f_n, f_total;
    logic [QI_W-1:0]              head;
    logic                         q_inf, q_neg;
    logic [K_W-1:0]               q_k;
    logic [ucb_pkg::SCORE_W-1:0]  q_mag;
    logic [COUNT_BITS-1:0]        q_n, q_total;

    // exploration weight register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= ucb_pkg::WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            weight_reg <= cfg_wdata;
        end
    end

    // front end
    ucb_front #(
        .COUNT_BITS (COUNT_BITS),
        .K_W        (K_W)
    ) u_front (
        .in_ch      (in_ch),
        .queue_full (full),
        .push       (push),
        .inf        (f_inf),
        .neg        (f_neg),
        .k          (f_k),
        .mag        (f_mag),
        .n          (f_n),
        .total      (f_total)
    );

    // queue
    ucb_queue #(
        .WIDTH (QI_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_inf, f_neg, f_k, f_mag, f_n, f_total}),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    assign {q_inf, q_neg, q_k, q_mag, q_n, q_total} = head;
    assign pop = adv && !empty;

    // back pipeline
    ucb_back #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .K_W        (K_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .weight  (weight_reg),
        .q_valid (!empty),
        .adv     (adv),
        .q_inf   (q_inf),
        .q_neg   (q_neg),
        .q_k     (q_k),
        .q_mag   (q_mag),
        .q_n     (q_n),
        .q_total (q_total),
        .out_ch  (out_ch)
    );

endmodule
`default_nettype wire

FILE: sv/ucb_checker.sv
// port level checks of the ucb1 score unit and their binding
`default_nettype none
module ucb_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [ucb_pkg::OUT_W-1:0] ucb_value,
    input wire logic                      is_infinite
);

    // infinite items always carry the maximum value
    a_inf_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_infinite |-> ucb_value == ucb_pkg::OUT_MAX)
        else $error("infinite item without maximum value");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result shown right after reset");

    // queue has room right after reset
    a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ucb_value) && $stable(is_infinite))
        else $error("stalled result changed");

endmodule

bind ucb1_score_unit ucb_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .ucb_value   (out_ch.ucb_value),
    .is_infinite (out_ch.is_infinite)
);
`default_nettype wire
